@@ hdl/core_hotplug_load_policy_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Hotplug load policy assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef CORE_HOTPLUG_LOAD_POLICY_UNIT_DEFINES_SVH
`define CORE_HOTPLUG_LOAD_POLICY_UNIT_DEFINES_SVH

// same-cycle implication, reset masks the check
`define HLP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hotplug policy check failed");

// next-cycle implication, reset masks the check
`define HLP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hotplug policy check failed");

`endif

@@ hdl/hlp_pkg.sv @@
// ---------------------------------------------------------------------------
// Hotplug load policy package
// Widths, reset values, codes and inter-module types.
// ---------------------------------------------------------------------------
package hlp_pkg;

  localparam int NUM_CORES  = 4;
  localparam int MASK_W     = 4;
  localparam int FREQ_W     = 24;
  localparam int PCT_W      = 7;
  localparam int CORES_W    = 3;
  localparam int TICK_W     = 8;
  localparam int CORE_IDX_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int PROD_W     = FREQ_W + PCT_W;
  localparam int PCT_SCALE  = 100;

  localparam logic [TICK_W-1:0]  TICK_MAX    = {TICK_W{1'b1}};
  localparam logic [PCT_W-1:0]   RST_UP_PCT  = PCT_W'(80);
  localparam logic [PCT_W-1:0]   RST_DN_PCT  = PCT_W'(50);
  localparam logic [CORES_W-1:0] RST_MAX_CRS = CORES_W'(4);
  localparam logic [CORES_W-1:0] RST_MIN_CRS = CORES_W'(1);
  localparam logic [TICK_W-1:0]  RST_TBU     = TICK_W'(1);
  localparam logic [TICK_W-1:0]  RST_TBD     = TICK_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_UP_PCT   = 3'd1,
    REG_DN_PCT   = 3'd2,
    REG_MAX_CRS  = 3'd3,
    REG_MIN_CRS  = 3'd4,
    REG_TBU      = 3'd5,
    REG_TBD      = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_UP   = 2'd1,
    ACT_DOWN = 2'd2
  } action_e;

  typedef struct packed {
    logic                enable;
    logic [PCT_W-1:0]    up_pct;
    logic [PCT_W-1:0]    dn_pct;
    logic [CORES_W-1:0]  max_cores;
    logic [CORES_W-1:0]  min_cores;
    logic [TICK_W-1:0]   ticks_up;
    logic [TICK_W-1:0]   ticks_dn;
  } hlp_cfg_t;

  // per-core lane result: rate plus its standing against both limits
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              above_up;
    logic              below_dn;
  } hlp_lane_t;

endpackage

@@ hdl/hlp_lane.sv @@
// ---------------------------------------------------------------------------
// Hotplug load policy core lane
// Scales one core rate by 100 and compares it against the limit products.
// ---------------------------------------------------------------------------
module hlp_lane (
  input  logic                      clk_i,
  input  logic                      load1_i,
  input  logic                      load2_i,
  input  logic [hlp_pkg::FREQ_W-1:0] freq_i,
  input  logic [hlp_pkg::PROD_W-1:0] up_prod_i,
  input  logic [hlp_pkg::PROD_W-1:0] dn_prod_i,
  output hlp_pkg::hlp_lane_t         lane_o
);
  import hlp_pkg::*;

  logic [FREQ_W-1:0] freq_q;
  logic [PROD_W-1:0] scaled_d, scaled_q;
  logic [PROD_W:0]   scaled_inc;
  hlp_lane_t         lane_d, lane_q;

  assign scaled_d = PROD_W'(freq_i) * PROD_W'(PCT_SCALE);

  always_ff @(posedge clk_i) begin
    if (load1_i) begin
      freq_q   <= freq_i;
      scaled_q <= scaled_d;
    end
  end

  // rate > floor(p/100)  <=>  p < 100*rate
  // rate < floor(p/100)  <=>  100*rate + 100 <= p
  assign scaled_inc      = {1'b0, scaled_q} + (PROD_W + 1)'(PCT_SCALE);
  assign lane_d.freq     = freq_q;
  assign lane_d.above_up = up_prod_i < scaled_q;
  assign lane_d.below_dn = scaled_inc <= {1'b0, dn_prod_i};

  always_ff @(posedge clk_i) begin
    if (load2_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

@@ hdl/hlp_merge.sv @@
// ---------------------------------------------------------------------------
// Hotplug load policy merge stage
// Resolves slowest and fastest core, applies tick gap and core limits.
// ---------------------------------------------------------------------------
module hlp_merge (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hlp_pkg::hlp_cfg_t                cfg_i,
  input  logic                             s2_valid_i,
  input  logic [hlp_pkg::MASK_W-1:0]       mask_i,
  input  hlp_pkg::hlp_lane_t               lane_i [hlp_pkg::NUM_CORES],
  input  logic                             out_stall_i,
  output logic                             ready_o,
  output logic                             out_valid_o,
  output logic [1:0]                       action_o,
  output logic [hlp_pkg::CORE_IDX_W-1:0]   target_core_o
);
  import hlp_pkg::*;

  logic                  out_valid_q;
  action_e               action_d, action_q;
  logic [CORE_IDX_W-1:0] target_d, target_q;
  logic [TICK_W-1:0]     ticks_d, ticks_q, ticks_inc;
  logic                  take;

  logic                  slow_none;
  logic [CORE_IDX_W-1:0] slow_idx;
  logic [FREQ_W-1:0]     slow_f, fast_f;
  logic                  slow_above, fast_below, fin_above;
  logic [CORES_W-1:0]    online;
  logic                  off_found;
  logic [CORE_IDX_W-1:0] off_idx;

  assign ready_o = !out_valid_q || !out_stall_i;
  assign take    = s2_valid_i && ready_o;

  // ascending scan, fastest only updated when a core is not the new slowest
  always_comb begin
    slow_none  = 1'b1;
    slow_idx   = '0;
    slow_f     = '0;
    slow_above = 1'b0;
    fast_f     = lane_i[0].freq;
    fast_below = lane_i[0].below_dn;
    for (int i = 1; i < NUM_CORES; i++) begin
      if (mask_i[i]) begin
        if (slow_none || lane_i[i].freq <= slow_f) begin
          slow_none  = 1'b0;
          slow_idx   = CORE_IDX_W'(i);
          slow_f     = lane_i[i].freq;
          slow_above = lane_i[i].above_up;
        end else if (lane_i[i].freq > fast_f) begin
          fast_f     = lane_i[i].freq;
          fast_below = lane_i[i].below_dn;
        end
      end
    end
    // core 0 rate wins the slowest value when lower, index unchanged
    if (slow_none || lane_i[0].freq < slow_f) begin
      fin_above = lane_i[0].above_up;
    end else begin
      fin_above = slow_above;
    end
  end

  always_comb begin
    online    = '0;
    off_found = 1'b0;
    off_idx   = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      online = online + CORES_W'(mask_i[i]);
    end
    for (int i = NUM_CORES - 1; i >= 1; i--) begin
      if (!mask_i[i]) begin
        off_found = 1'b1;
        off_idx   = CORE_IDX_W'(i);
      end
    end
  end

  assign ticks_inc = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + TICK_W'(1);

  always_comb begin
    action_d = ACT_NONE;
    target_d = '0;
    ticks_d  = ticks_q;
    if (cfg_i.enable) begin
      ticks_d = ticks_inc;
      if (fin_above) begin
        if (online < cfg_i.max_cores && ticks_inc >= cfg_i.ticks_up) begin
          ticks_d = '0;
          if (off_found) begin
            action_d = ACT_UP;
            target_d = off_idx;
          end
        end
      end else if (slow_idx != '0 && fast_below) begin
        if (online > cfg_i.min_cores && ticks_inc >= cfg_i.ticks_dn) begin
          ticks_d  = '0;
          action_d = ACT_DOWN;
          target_d = slow_idx;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      ticks_q     <= '0;
    end else begin
      if (ready_o) begin
        out_valid_q <= s2_valid_i;
      end
      if (take) begin
        ticks_q <= ticks_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      action_q <= action_d;
      target_q <= target_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = action_q;
  assign target_core_o = target_q;

endmodule

@@ hdl/core_hotplug_load_policy_unit.sv @@
// ---------------------------------------------------------------------------
// Core hotplug load policy unit
// Per-tick decision to bring a core up, take one down, or hold.
// ---------------------------------------------------------------------------
// One request per evaluation tick gives exactly one result. The unit takes a
// new request every cycle while in_stall_o is low and passes each request
// through three registered stages:
// the first stage forms both limit products and the per-core rate times 100,
// the second has one lane per core comparing its rate against the limits,
// and the third merges the lanes in core order, applies the tick gap and the
// core-count limits and holds the result in the output register. Limits are
// compared against the scaled rates, so no divider is needed. Back-pressure
// on the result side stalls the input only once all three stages are full.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i and should
// change only while no request is in flight.
// ---------------------------------------------------------------------------
module core_hotplug_load_policy_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [hlp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [hlp_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [hlp_pkg::FREQ_W-1:0]        max_freq_i,
  input  logic [hlp_pkg::FREQ_W-1:0]        freq_core0_i,
  input  logic [hlp_pkg::FREQ_W-1:0]        freq_core1_i,
  input  logic [hlp_pkg::FREQ_W-1:0]        freq_core2_i,
  input  logic [hlp_pkg::FREQ_W-1:0]        freq_core3_i,
  input  logic [hlp_pkg::MASK_W-1:0]        online_mask_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        action_o,
  output logic [hlp_pkg::CORE_IDX_W-1:0]    target_core_o
);
  import hlp_pkg::*;

  hlp_cfg_t          cfg_q;
  logic              s1_valid_q, s2_valid_q;
  logic              adv1, adv2, merge_ready;
  logic              load1, load2;
  logic [MASK_W-1:0] mask1_q, mask2_q;
  logic [PROD_W-1:0] up_prod_q, dn_prod_q;
  logic [FREQ_W-1:0] freq_in [NUM_CORES];
  hlp_lane_t         lane   [NUM_CORES];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable    <= 1'b1;
      cfg_q.up_pct    <= RST_UP_PCT;
      cfg_q.dn_pct    <= RST_DN_PCT;
      cfg_q.max_cores <= RST_MAX_CRS;
      cfg_q.min_cores <= RST_MIN_CRS;
      cfg_q.ticks_up  <= RST_TBU;
      cfg_q.ticks_dn  <= RST_TBD;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ENABLE:  cfg_q.enable    <= cfg_wdata_i[0];
        REG_UP_PCT:  cfg_q.up_pct    <= cfg_wdata_i[PCT_W-1:0];
        REG_DN_PCT:  cfg_q.dn_pct    <= cfg_wdata_i[PCT_W-1:0];
        REG_MAX_CRS: cfg_q.max_cores <= cfg_wdata_i[CORES_W-1:0];
        REG_MIN_CRS: cfg_q.min_cores <= cfg_wdata_i[CORES_W-1:0];
        REG_TBU:     cfg_q.ticks_up  <= cfg_wdata_i[TICK_W-1:0];
        REG_TBD:     cfg_q.ticks_dn  <= cfg_wdata_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance
  assign adv2       = !s2_valid_q || merge_ready;
  assign adv1       = !s1_valid_q || adv2;
  assign in_stall_o = !adv1;
  assign load1      = in_valid_i && adv1;
  assign load2      = s1_valid_q && adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (adv1) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load1) begin
      up_prod_q <= PROD_W'(cfg_q.up_pct) * PROD_W'(max_freq_i);
      dn_prod_q <= PROD_W'(cfg_q.dn_pct) * PROD_W'(max_freq_i);
      mask1_q   <= online_mask_i;
    end
    if (load2) begin
      mask2_q <= mask1_q;
    end
  end

  assign freq_in[0] = freq_core0_i;
  assign freq_in[1] = freq_core1_i;
  assign freq_in[2] = freq_core2_i;
  assign freq_in[3] = freq_core3_i;

  for (genvar g = 0; g < NUM_CORES; g++) begin : g_lane
    hlp_lane u_lane (
      .clk_i     (clk_i),
      .load1_i   (load1),
      .load2_i   (load2),
      .freq_i    (freq_in[g]),
      .up_prod_i (up_prod_q),
      .dn_prod_i (dn_prod_q),
      .lane_o    (lane[g])
    );
  end

  hlp_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s2_valid_i    (s2_valid_q),
    .mask_i        (mask2_q),
    .lane_i        (lane),
    .out_stall_i   (out_stall_i),
    .ready_o       (merge_ready),
    .out_valid_o   (out_valid_o),
    .action_o      (action_o),
    .target_core_o (target_core_o)
  );

endmodule

@@ hdl/hlp_checker.sv @@
// ---------------------------------------------------------------------------
// Hotplug load policy port checker
// Port-level properties, bound to the top level.
// ---------------------------------------------------------------------------
`include "core_hotplug_load_policy_unit_defines.svh"

module hlp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [1:0]                        action_o,
  input logic [hlp_pkg::CORE_IDX_W-1:0]    target_core_o
);
  import hlp_pkg::*;

  // stalled result holds
  `HLP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i,
                  out_valid_o && $stable(action_o) && $stable(target_core_o))

  // no action always names core 0
  `HLP_ASSERT_IMP(a_none_core0, out_valid_o && action_o == ACT_NONE,
                  target_core_o == '0)

  // core 0 is never brought up or taken down
  `HLP_ASSERT_IMP(a_act_not_core0,
                  out_valid_o && (action_o == ACT_UP || action_o == ACT_DOWN),
                  target_core_o != '0)

  // input back-pressure only comes from a stalled result
  `HLP_ASSERT_IMP(a_stall_source, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind core_hotplug_load_policy_unit hlp_checker u_hlp_checker (.*);

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// Hotplug load policy unit testbench
// Drives evaluation ticks through the valid/stall ports under random idling
// and back-pressure, predicts each up/down/hold decision in a scoreboard and
// compares every returned decision in order.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hlp_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 11;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int HOLD_CYCLES     = 80;
  localparam int MAX_PRINTS      = 50;

  typedef struct packed {
    logic [FREQ_W-1:0]                  max_freq;
    logic [NUM_CORES-1:0][FREQ_W-1:0]   freq;
    logic [MASK_W-1:0]                  mask;
  } tick_t;

  typedef struct packed {
    action_e                 act;
    logic [CORE_IDX_W-1:0]   core;
  } decision_t;

  class decision_scoreboard;
    hlp_cfg_t            cfg;
    logic [TICK_W-1:0]   ticks_since;
    decision_t           decisions_due[$];
    int                  errors;

    function new();
      cfg.enable    = 1'b1;
      cfg.up_pct    = RST_UP_PCT;
      cfg.dn_pct    = RST_DN_PCT;
      cfg.max_cores = RST_MAX_CRS;
      cfg.min_cores = RST_MIN_CRS;
      cfg.ticks_up  = RST_TBU;
      cfg.ticks_dn  = RST_TBD;
      ticks_since   = '0;
      errors        = 0;
    endfunction

    static function logic [PROD_W-1:0] scaled_limit(logic [PCT_W-1:0] pct,
                                                    logic [FREQ_W-1:0] maxf);
      return PROD_W'((PROD_W'(pct) * PROD_W'(maxf)) / PCT_SCALE);
    endfunction

    function int pending();
      return decisions_due.size();
    endfunction

    function void write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_ENABLE:  cfg.enable    = v[0];
        REG_UP_PCT:  cfg.up_pct    = v[PCT_W-1:0];
        REG_DN_PCT:  cfg.dn_pct    = v[PCT_W-1:0];
        REG_MAX_CRS: cfg.max_cores = v[CORES_W-1:0];
        REG_MIN_CRS: cfg.min_cores = v[CORES_W-1:0];
        REG_TBU:     cfg.ticks_up  = v[TICK_W-1:0];
        REG_TBD:     cfg.ticks_dn  = v[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // one accepted tick: update the gap counter and queue the decision
    function void take_tick(tick_t t);
      logic [PROD_W-1:0]     up_lim, dn_lim;
      logic [31:0]           slow, fast;
      logic [CORE_IDX_W-1:0] slow_core;
      int                    online;
      bit                    found;
      decision_t             d;
      d.act  = ACT_NONE;
      d.core = '0;
      if (cfg.enable) begin
        if (ticks_since != TICK_MAX) ticks_since++;
        up_lim = scaled_limit(cfg.up_pct, t.max_freq);
        dn_lim = scaled_limit(cfg.dn_pct, t.max_freq);
        online = 0;
        for (int i = 0; i < NUM_CORES; i++) if (t.mask[i]) online++;
        fast      = 32'(t.freq[0]);
        slow      = '1;
        slow_core = '0;
        // a core that becomes the slowest is never also tried as the fastest
        for (int i = 1; i < NUM_CORES; i++) begin
          if (t.mask[i]) begin
            if (32'(t.freq[i]) <= slow) begin
              slow_core = CORE_IDX_W'(i);
              slow      = 32'(t.freq[i]);
            end else if (32'(t.freq[i]) > fast) begin
              fast = 32'(t.freq[i]);
            end
          end
        end
        if (32'(t.freq[0]) < slow) slow = 32'(t.freq[0]);
        if (slow > up_lim) begin
          if (online < cfg.max_cores && ticks_since >= cfg.ticks_up) begin
            found = 1'b0;
            for (int i = 1; i < NUM_CORES; i++) begin
              if (!found && !t.mask[i]) begin
                found  = 1'b1;
                d.act  = ACT_UP;
                d.core = CORE_IDX_W'(i);
              end
            end
            ticks_since = '0;
          end
        end else if (slow_core != 0 && fast < dn_lim) begin
          if (online > cfg.min_cores && ticks_since >= cfg.ticks_dn) begin
            d.act       = ACT_DOWN;
            d.core      = slow_core;
            ticks_since = '0;
          end
        end
      end
      decisions_due.push_back(d);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_decision(logic [1:0] got_act, logic [CORE_IDX_W-1:0] got_core);
      decision_t want;
      if (decisions_due.size() == 0) begin
        report($sformatf("decision act=%0d core=%0d with no request pending",
                         got_act, got_core));
      end else begin
        want = decisions_due.pop_front();
        if (got_act !== want.act)
          report($sformatf("action %0d, want %s", got_act, want.act.name()));
        if (got_core !== want.core)
          report($sformatf("target_core %0d, want %0d", got_core, want.core));
      end
    endtask
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [FREQ_W-1:0]        max_freq_i;
  logic [FREQ_W-1:0]        freq_core0_i;
  logic [FREQ_W-1:0]        freq_core1_i;
  logic [FREQ_W-1:0]        freq_core2_i;
  logic [FREQ_W-1:0]        freq_core3_i;
  logic [MASK_W-1:0]        online_mask_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [1:0]               action_o;
  logic [CORE_IDX_W-1:0]    target_core_o;

  decision_scoreboard board;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_req;
  int quiet_cycles = 0;

  core_hotplug_load_policy_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .max_freq_i    (max_freq_i),
    .freq_core0_i  (freq_core0_i),
    .freq_core1_i  (freq_core1_i),
    .freq_core2_i  (freq_core2_i),
    .freq_core3_i  (freq_core3_i),
    .online_mask_i (online_mask_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .target_core_o (target_core_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // result side stall; a requested hold-off is counted down here
  initial begin : rx_side
    int hold;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req != 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold != 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // ports are stable between negedge and the accepting posedge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_decision(action_o, target_core_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("core_hotplug_load_policy_unit regression: fail");
        $finish;
      end
    end
  end

  function automatic logic [FREQ_W-1:0] sat_freq(logic [63:0] v);
    return (v > 64'({FREQ_W{1'b1}})) ? {FREQ_W{1'b1}} : v[FREQ_W-1:0];
  endfunction

  function automatic tick_t mk_tick(logic [FREQ_W-1:0] maxf, logic [FREQ_W-1:0] f0,
                                    logic [FREQ_W-1:0] f1, logic [FREQ_W-1:0] f2,
                                    logic [FREQ_W-1:0] f3, logic [MASK_W-1:0] m);
    tick_t t;
    t.max_freq = maxf;
    t.freq[0]  = f0;
    t.freq[1]  = f1;
    t.freq[2]  = f2;
    t.freq[3]  = f3;
    t.mask     = m;
    return t;
  endfunction

  function automatic hlp_cfg_t mk_cfg(logic en, int up, int dn, int mx, int mn,
                                      int tu, int td);
    hlp_cfg_t c;
    c.enable    = en;
    c.up_pct    = PCT_W'(up);
    c.dn_pct    = PCT_W'(dn);
    c.max_cores = CORES_W'(mx);
    c.min_cores = CORES_W'(mn);
    c.ticks_up  = TICK_W'(tu);
    c.ticks_dn  = TICK_W'(td);
    return c;
  endfunction

  function automatic logic [TICK_W-1:0] pick_gap();
    case ($urandom_range(9))
      7, 8:    return TICK_W'($urandom_range(20, 4));
      9:       return TICK_W'($urandom);
      default: return TICK_W'($urandom_range(3));
    endcase
  endfunction

  function automatic hlp_cfg_t random_cfg();
    hlp_cfg_t c;
    c.enable    = 1'b1;
    c.up_pct    = ($urandom_range(4) != 0) ? PCT_W'($urandom_range(100, 40))
                                           : PCT_W'($urandom);
    c.dn_pct    = ($urandom_range(4) != 0) ? PCT_W'($urandom_range(70, 5))
                                           : PCT_W'($urandom);
    c.max_cores = ($urandom_range(4) != 0) ? CORES_W'($urandom_range(4, 1))
                                           : CORES_W'($urandom);
    c.min_cores = ($urandom_range(4) != 0) ? CORES_W'($urandom_range(4, 1))
                                           : CORES_W'($urandom);
    c.ticks_up  = pick_gap();
    c.ticks_dn  = pick_gap();
    return c;
  endfunction

  // busy, idle, near a limit or anything; a core now and then ignores the trend
  function automatic logic [FREQ_W-1:0] pick_freq(int kind, logic [63:0] up_lim,
                                                  logic [63:0] dn_lim);
    if ($urandom_range(7) == 0) return FREQ_W'($urandom);
    if (kind < 4) return sat_freq(up_lim + 1 + $urandom_range(32'(up_lim >> 3) + 1));
    if (kind < 8) return (dn_lim == 0) ? '0 : sat_freq($urandom_range(32'(dn_lim) - 1));
    if (kind == 8) begin
      case ($urandom_range(3))
        0:       return sat_freq(up_lim);
        1:       return sat_freq(up_lim + 1);
        2:       return sat_freq(dn_lim);
        default: return (dn_lim == 0) ? '0 : sat_freq(dn_lim - 1);
      endcase
    end
    return FREQ_W'($urandom);
  endfunction

  function automatic tick_t random_tick();
    tick_t t;
    logic [63:0] up_lim, dn_lim;
    int kind;
    case ($urandom_range(9))
      0:       t.max_freq = '0;
      1:       t.max_freq = '1;
      2, 3, 4: t.max_freq = FREQ_W'($urandom);
      default: t.max_freq = FREQ_W'($urandom_range(3000000, 500));
    endcase
    t.mask = ($urandom_range(3) == 0) ? MASK_W'($urandom)
                                      : (MASK_W'($urandom) | MASK_W'(1));
    up_lim = 64'(board.scaled_limit(board.cfg.up_pct, t.max_freq));
    dn_lim = 64'(board.scaled_limit(board.cfg.dn_pct, t.max_freq));
    kind   = $urandom_range(9);
    for (int k = 0; k < NUM_CORES; k++) t.freq[k] = pick_freq(kind, up_lim, dn_lim);
    return t;
  endfunction

  // starts and ends on a posedge; the tick is taken at the final edge
  task automatic send_tick(input tick_t t);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    max_freq_i    <= t.max_freq;
    freq_core0_i  <= t.freq[0];
    freq_core1_i  <= t.freq[1];
    freq_core2_i  <= t.freq[2];
    freq_core3_i  <= t.freq[3];
    online_mask_i <= t.mask;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    board.take_tick(t);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e r, input logic [CFG_DATA_W-1:0] v);
    cfg_idx_i   <= r;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.write_reg(r, v);
  endtask

  // unused upper data bits carry noise
  task automatic load_cfg(input hlp_cfg_t c);
    settle();
    cfg_we_i <= 1'b1;
    put_reg(REG_ENABLE,  {7'($urandom), c.enable});
    put_reg(REG_UP_PCT,  {1'($urandom), c.up_pct});
    put_reg(REG_DN_PCT,  {1'($urandom), c.dn_pct});
    put_reg(REG_MAX_CRS, {5'($urandom), c.max_cores});
    put_reg(REG_MIN_CRS, {5'($urandom), c.min_cores});
    put_reg(REG_TBU,     c.ticks_up);
    put_reg(REG_TBD,     c.ticks_dn);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    hlp_cfg_t c;
    int n_ticks;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_ENABLE;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    max_freq_i    = '0;
    freq_core0_i  = '0;
    freq_core1_i  = '0;
    freq_core2_i  = '0;
    freq_core3_i  = '0;
    online_mask_i = '0;
    tx_idle_pct   = 37;
    rx_idle_pct   = 64;
    rx_hold_req   = 0;
    board         = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: bring cores up one by one, then hit the ceiling
    send_tick(mk_tick(1000, 900, 900, 900, 900, 4'b0001));
    send_tick(mk_tick(1000, 900, 900, 900, 900, 4'b0011));
    send_tick(mk_tick(1000, 900, 900, 900, 900, 4'b0111));
    send_tick(mk_tick(1000, 900, 900, 900, 900, 4'b1111));
    // core 0 marked offline, nothing left to bring up
    send_tick(mk_tick(1000, 900, 900, 900, 900, 4'b1110));
    send_tick(mk_tick(1000, 100, 100, 100, 100, 4'b1111));
    send_tick(mk_tick(1000, 100, 100, 100, 100, 4'b1111));
    send_tick(mk_tick(1000, 100, 100, 100, 100, 4'b0001));
    send_tick(mk_tick(1000, 100, 100, 100, 100, 4'b0000));
    send_tick(mk_tick(1000, 100, 300, 200, 400, 4'b1111));
    // fast core 1 taken as slowest first and so never seen as fastest
    send_tick(mk_tick(1000, 100, 900, 100, 100, 4'b1111));
    send_tick(mk_tick(0, 0, 0, 0, 0, 4'b1111));
    send_tick(mk_tick('1, '1, '1, '1, '1, 4'b0001));
    send_tick(mk_tick(1000, 800, 800, 800, 800, 4'b0011));
    send_tick(mk_tick(1000, 801, 801, 801, 801, 4'b0011));
    send_tick(mk_tick(1000, 500, 500, 500, 500, 4'b1111));
    send_tick(mk_tick(1000, 499, 499, 499, 499, 4'b1111));
    load_cfg(mk_cfg(1'b0, 80, 50, 4, 1, 1, 2));
    send_tick(mk_tick(1000, 900, 900, 900, 900, 4'b0001));
    send_tick(mk_tick(1000, 100, 100, 100, 100, 4'b1111));
    load_cfg(mk_cfg(1'b1, 127, 127, 7, 0, 0, 0));
    send_tick(mk_tick(1000, 900, 900, 900, 900, 4'b0001));
    send_tick(mk_tick('1, '1, '1, '1, '1, 4'b0001));
    send_tick(mk_tick(0, 0, 0, 0, 0, 4'b1111));
    load_cfg(mk_cfg(1'b1, 0, 0, 1, 4, 255, 255));
    send_tick(mk_tick(1000, 1, 1, 1, 1, 4'b0001));
    send_tick(mk_tick(0, '1, '1, '1, '1, 4'b1111));

    for (int ph = 0; ph < 8; ph++) begin
      c       = random_cfg();
      n_ticks = 125;
      case (ph)
        1: c = mk_cfg(1'b1, 127, 127, 7, 0, 0, 0);
        3: begin
          c.enable = 1'b0;
          n_ticks  = 30;
        end
        5: begin
          // long enough for the gap counter to saturate
          c.ticks_up = TICK_MAX;
          c.ticks_dn = TICK_MAX;
          n_ticks    = 300;
        end
        7: c = mk_cfg(1'b1, 0, 100, 4, 1, 0, 0);
        default: ;
      endcase
      tx_idle_pct = (ph < 3) ? 37 : (ph < 6) ? 64 : 0;
      rx_idle_pct = (ph < 3) ? 64 : (ph < 6) ? 37 : 0;
      load_cfg(c);
      // result side holds off while requests keep coming, filling the pipe
      if (ph == 6) rx_hold_req = HOLD_CYCLES;
      repeat (n_ticks) send_tick(random_tick());
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0)
      $display("core_hotplug_load_policy_unit regression: pass");
    else
      $display("core_hotplug_load_policy_unit regression: fail");
    $finish;
  end

endmodule
